>>> sv/jas_pkg.sv
// Shared types, constants and lookup functions for the joystick axis shaper.
// Used by the channel interfaces, the per-axis shaper, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jas_pkg;

  localparam int RAW_W  = 8;
  localparam int CMD_W  = 8;
  localparam int MAG_W  = 7;
  localparam int VEL_W  = 16;
  localparam int CFG_W  = 7;
  localparam int EPS_W  = 15;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // raw stick centre
  localparam logic [RAW_W-1:0] AXIS_CENTER = 8'd127;
  localparam logic [MAG_W-1:0] FULL_SCALE  = 7'd127;

  // reciprocal of ten in 11 fractional bits, exact for values below 1029
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int         DIV10_SHIFT = 11;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTER_SNAP      = 3'd0,
    REG_DRIVE_DZ         = 3'd1,
    REG_TURN_DZ          = 3'd2,
    REG_FWD_STRAIGHT_LO  = 3'd3,
    REG_SIDE_STRAIGHT_HI = 3'd4,
    REG_TURN_DRIFT_HI    = 3'd5,
    REG_VELOCITY_EPSILON = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] center_snap;
    logic [CFG_W-1:0] drive_dz;
    logic [CFG_W-1:0] turn_dz;
    logic [CFG_W-1:0] fwd_straight_lo;
    logic [CFG_W-1:0] side_straight_hi;
    logic [CFG_W-1:0] turn_drift_hi;
    logic [EPS_W-1:0] velocity_epsilon;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_snap:      7'd2,
    drive_dz:         7'd4,
    turn_dz:          7'd8,
    fwd_straight_lo:  7'd20,
    side_straight_hi: 7'd10,
    turn_drift_hi:    7'd12,
    velocity_epsilon: 15'd3
  };

  // one accepted stick item
  typedef struct packed {
    logic [RAW_W-1:0]        raw_forward;
    logic [RAW_W-1:0]        raw_strafe;
    logic [RAW_W-1:0]        raw_rotate;
    logic signed [VEL_W-1:0] vel_forward;
    logic signed [VEL_W-1:0] vel_strafe;
    logic signed [VEL_W-1:0] vel_rotate;
    logic                    low_speed;
  } stick_item_t;

  // shaped axis command as sign and magnitude; neg is only set with a nonzero magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } axis_cmd_t;

  // exponential response curve, rounded
  localparam logic [MAG_W-1:0] EXPO_ROM [128] = '{
    7'd0,
    7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2,
    7'd2, 7'd2, 7'd2, 7'd3, 7'd3, 7'd3, 7'd3, 7'd4, 7'd4, 7'd4,
    7'd4, 7'd5, 7'd5, 7'd5, 7'd5, 7'd6, 7'd6, 7'd6, 7'd7, 7'd7,
    7'd7, 7'd8, 7'd8, 7'd8, 7'd9, 7'd9, 7'd9, 7'd10, 7'd10, 7'd10,
    7'd11, 7'd11, 7'd12, 7'd12, 7'd13, 7'd13, 7'd14, 7'd14, 7'd15, 7'd15,
    7'd16, 7'd16, 7'd17, 7'd17, 7'd18, 7'd18, 7'd19, 7'd20, 7'd20, 7'd21,
    7'd21, 7'd22, 7'd23, 7'd24, 7'd24, 7'd25, 7'd26, 7'd27, 7'd27, 7'd28,
    7'd29, 7'd30, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37,
    7'd38, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd47, 7'd48, 7'd49,
    7'd50, 7'd52, 7'd53, 7'd55, 7'd56, 7'd58, 7'd59, 7'd61, 7'd62, 7'd64,
    7'd66, 7'd67, 7'd69, 7'd71, 7'd73, 7'd75, 7'd77, 7'd79, 7'd81, 7'd83,
    7'd85, 7'd87, 7'd89, 7'd92, 7'd94, 7'd96, 7'd99, 7'd101, 7'd104, 7'd107,
    7'd109, 7'd112, 7'd115, 7'd118, 7'd121, 7'd124, 7'd127
  };

  function automatic logic [MAG_W-1:0] expo_lookup(input logic [MAG_W-1:0] m);
    return EXPO_ROM[m];
  endfunction

  // truncating divide by ten through a reciprocal multiply
  function automatic logic [MAG_W-1:0] div10(input logic [MAG_W-1:0] s);
    logic [MAG_W+8-1:0] p;
    p = {8'd0, s} * {7'd0, DIV10_MUL};
    return MAG_W'(p >> DIV10_SHIFT);
  endfunction

  // zero a command whose sign opposes a velocity above the epsilon
  function automatic axis_cmd_t reversal_gate(input axis_cmd_t c,
                                              input logic signed [VEL_W-1:0] v,
                                              input logic [EPS_W-1:0] eps);
    logic [VEL_W-1:0] vmag;
    logic             moving;
    logic             vel_pos;
    logic             opposes;
    axis_cmd_t        r;
    vmag    = v[VEL_W-1] ? VEL_W'(-v) : VEL_W'(v);
    moving  = vmag > {1'b0, eps};
    vel_pos = !v[VEL_W-1] && (v != '0);
    opposes = (c.mag != '0) && ((!c.neg && v[VEL_W-1]) || (c.neg && vel_pos));
    r = (moving && opposes) ? axis_cmd_t'('0) : c;
    return r;
  endfunction

  function automatic logic signed [CMD_W-1:0] to_cmd(input axis_cmd_t c);
    logic [CMD_W-1:0] m;
    m = {1'b0, c.mag};
    return c.neg ? CMD_W'(-m) : m;
  endfunction

endpackage

`default_nettype wire

>>> sv/jas_if.sv
// Valid/ready channel interfaces for stick items and shaped command items.
// Depends on jas_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface jas_stick_if;
  logic                                    valid;
  logic                                    ready;
  logic [jas_pkg::RAW_W-1:0]               raw_forward;
  logic [jas_pkg::RAW_W-1:0]               raw_strafe;
  logic [jas_pkg::RAW_W-1:0]               raw_rotate;
  logic signed [jas_pkg::VEL_W-1:0]        vel_forward;
  logic signed [jas_pkg::VEL_W-1:0]        vel_strafe;
  logic signed [jas_pkg::VEL_W-1:0]        vel_rotate;
  logic                                    low_speed;

  modport source (output valid, raw_forward, raw_strafe, raw_rotate,
                  vel_forward, vel_strafe, vel_rotate, low_speed, input ready);
  modport sink   (input valid, raw_forward, raw_strafe, raw_rotate,
                  vel_forward, vel_strafe, vel_rotate, low_speed, output ready);
endinterface

interface jas_cmd_if;
  logic                             valid;
  logic                             ready;
  logic signed [jas_pkg::CMD_W-1:0] cmd_forward;
  logic signed [jas_pkg::CMD_W-1:0] cmd_strafe;
  logic signed [jas_pkg::CMD_W-1:0] cmd_rotate;
  logic                             drift_clamped;

  modport source (output valid, cmd_forward, cmd_strafe, cmd_rotate, drift_clamped,
                  input ready);
  modport sink   (input valid, cmd_forward, cmd_strafe, cmd_rotate, drift_clamped,
                  output ready);
endinterface

`default_nettype wire

>>> sv/joystick_axis_shaper.sv
// Top level of the joystick axis shaper: APB register file, input stage, result stage.
// Depends on jas_pkg, jas_if and jas_axis.
`timescale 1ns / 1ps
`default_nettype none

// Takes one stick item per clock and returns one shaped command item for each.
// An accepted item is held in the input register while the three axis shapers,
// the straight-driving rule and the reversal gates run, and its result lands in
// the output register, from which it is presented; one item per cycle is
// sustained while the command channel takes results. Only back-pressure on the
// command channel stalls the stick channel, and an item is still taken while a
// result waits as long as the input register is free. Registers sit on an APB
// port at byte address 4*index and should be written while no item is in flight.
module joystick_axis_shaper (
  input  wire logic                        clk,
  input  wire logic                        rst,
  jas_stick_if.sink                        stick,
  jas_cmd_if.source                        cmd,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jas_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [jas_pkg::DATA_W-1:0]  pwdata,
  output logic      [jas_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  jas_pkg::cfg_t        cfg;
  jas_pkg::reg_idx_t    reg_idx;
  logic                 cfg_write;

  logic                 s1_valid;
  jas_pkg::stick_item_t s1_item;
  logic                 s1_move;

  jas_pkg::axis_cmd_t   fwd_shaped;
  jas_pkg::axis_cmd_t   str_shaped;
  jas_pkg::axis_cmd_t   rot_shaped;
  logic                 straight;
  jas_pkg::axis_cmd_t   rot_kept;
  jas_pkg::axis_cmd_t   fwd_gated;
  jas_pkg::axis_cmd_t   str_gated;
  jas_pkg::axis_cmd_t   rot_gated;

  // register port
  assign pready    = 1'b1;
  assign reg_idx   = jas_pkg::reg_idx_t'(paddr[jas_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= jas_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        jas_pkg::REG_CENTER_SNAP:      cfg.center_snap <= pwdata[jas_pkg::CFG_W-1:0];
        jas_pkg::REG_DRIVE_DZ:         cfg.drive_dz <= pwdata[jas_pkg::CFG_W-1:0];
        jas_pkg::REG_TURN_DZ:          cfg.turn_dz <= pwdata[jas_pkg::CFG_W-1:0];
        jas_pkg::REG_FWD_STRAIGHT_LO:  cfg.fwd_straight_lo <= pwdata[jas_pkg::CFG_W-1:0];
        jas_pkg::REG_SIDE_STRAIGHT_HI: cfg.side_straight_hi <= pwdata[jas_pkg::CFG_W-1:0];
        jas_pkg::REG_TURN_DRIFT_HI:    cfg.turn_drift_hi <= pwdata[jas_pkg::CFG_W-1:0];
        jas_pkg::REG_VELOCITY_EPSILON: cfg.velocity_epsilon <= pwdata[jas_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      jas_pkg::REG_CENTER_SNAP:      prdata = jas_pkg::DATA_W'(cfg.center_snap);
      jas_pkg::REG_DRIVE_DZ:         prdata = jas_pkg::DATA_W'(cfg.drive_dz);
      jas_pkg::REG_TURN_DZ:          prdata = jas_pkg::DATA_W'(cfg.turn_dz);
      jas_pkg::REG_FWD_STRAIGHT_LO:  prdata = jas_pkg::DATA_W'(cfg.fwd_straight_lo);
      jas_pkg::REG_SIDE_STRAIGHT_HI: prdata = jas_pkg::DATA_W'(cfg.side_straight_hi);
      jas_pkg::REG_TURN_DRIFT_HI:    prdata = jas_pkg::DATA_W'(cfg.turn_drift_hi);
      jas_pkg::REG_VELOCITY_EPSILON: prdata = jas_pkg::DATA_W'(cfg.velocity_epsilon);
      default:                       prdata = '0;
    endcase
  end

  // pipeline flow control
  assign s1_move     = s1_valid && (!cmd.valid || cmd.ready);
  assign stick.ready = !s1_valid || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stick.ready) begin
      s1_valid <= stick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stick.valid && stick.ready) begin
      s1_item.raw_forward <= stick.raw_forward;
      s1_item.raw_strafe  <= stick.raw_strafe;
      s1_item.raw_rotate  <= stick.raw_rotate;
      s1_item.vel_forward <= stick.vel_forward;
      s1_item.vel_strafe  <= stick.vel_strafe;
      s1_item.vel_rotate  <= stick.vel_rotate;
      s1_item.low_speed   <= stick.low_speed;
    end
  end

  // per-axis shaping
  jas_axis u_fwd (
    .raw      (s1_item.raw_forward),
    .snap     (cfg.center_snap),
    .deadzone (cfg.drive_dz),
    .low      (s1_item.low_speed),
    .cmd      (fwd_shaped)
  );

  jas_axis u_str (
    .raw      (s1_item.raw_strafe),
    .snap     (cfg.center_snap),
    .deadzone (cfg.drive_dz),
    .low      (s1_item.low_speed),
    .cmd      (str_shaped)
  );

  jas_axis u_rot (
    .raw      (s1_item.raw_rotate),
    .snap     (cfg.center_snap),
    .deadzone (cfg.turn_dz),
    .low      (s1_item.low_speed),
    .cmd      (rot_shaped)
  );

  // straight-driving rule drops small rotate
  assign straight = (fwd_shaped.mag >= cfg.fwd_straight_lo) &&
                    (str_shaped.mag <= cfg.side_straight_hi) &&
                    (rot_shaped.mag <= cfg.turn_drift_hi);
  assign rot_kept = straight ? jas_pkg::axis_cmd_t'('0) : rot_shaped;

  // reversal gates
  assign fwd_gated = jas_pkg::reversal_gate(fwd_shaped, s1_item.vel_forward,
                                            cfg.velocity_epsilon);
  assign str_gated = jas_pkg::reversal_gate(str_shaped, s1_item.vel_strafe,
                                            cfg.velocity_epsilon);
  assign rot_gated = jas_pkg::reversal_gate(rot_kept, s1_item.vel_rotate,
                                            cfg.velocity_epsilon);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      cmd.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      cmd.cmd_forward   <= jas_pkg::to_cmd(fwd_gated);
      cmd.cmd_strafe    <= jas_pkg::to_cmd(str_gated);
      cmd.cmd_rotate    <= jas_pkg::to_cmd(rot_gated);
      cmd.drift_clamped <= straight;
    end
  end

endmodule

`default_nettype wire

>>> sv/jas_axis.sv
// Shapes one stick axis: centre, snap, clamp, deadzone, expo curve, low-speed divide.
// Depends on jas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jas_axis (
  input  wire logic [jas_pkg::RAW_W-1:0] raw,
  input  wire logic [jas_pkg::CFG_W-1:0] snap,
  input  wire logic [jas_pkg::CFG_W-1:0] deadzone,
  input  wire logic                      low,
  output jas_pkg::axis_cmd_t             cmd
);

  logic                      below;
  logic [jas_pkg::RAW_W-1:0] mag8;
  logic [jas_pkg::MAG_W-1:0] mag;
  logic                      zeroed;
  logic [jas_pkg::MAG_W-1:0] curve;
  logic [jas_pkg::MAG_W-1:0] scaled;

  // centred magnitude and sign
  assign below = raw < jas_pkg::AXIS_CENTER;
  assign mag8  = below ? (jas_pkg::AXIS_CENTER - raw) : (raw - jas_pkg::AXIS_CENTER);

  // clamp the one value above full scale
  assign mag = mag8[jas_pkg::RAW_W-1] ? jas_pkg::FULL_SCALE : mag8[jas_pkg::MAG_W-1:0];

  // snap to centre, then deadzone on the clamped value
  assign zeroed = (mag8 <= {1'b0, snap}) || (mag <= deadzone);

  // response curve and optional tenfold reduction
  assign curve  = jas_pkg::expo_lookup(mag);
  assign scaled = low ? jas_pkg::div10(curve) : curve;

  always_comb begin
    cmd.mag = zeroed ? '0 : scaled;
    cmd.neg = below && (cmd.mag != '0);
  end

endmodule

`default_nettype wire

>>> sv/jas_checker.sv
// Port-level checker for the joystick axis shaper, bound to the top level.
// Depends on jas_pkg and on the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module jas_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cmd_valid,
  input wire logic                             cmd_ready,
  input wire logic signed [jas_pkg::CMD_W-1:0] cmd_forward,
  input wire logic signed [jas_pkg::CMD_W-1:0] cmd_strafe,
  input wire logic signed [jas_pkg::CMD_W-1:0] cmd_rotate,
  input wire logic                             drift_clamped
);

  localparam logic signed [jas_pkg::CMD_W-1:0] CMD_NEG_FULL = 8'sh80;

  // no result leaves in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !cmd_valid)
    else $error("result valid right after reset");

  // commands stay within plus or minus full scale
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd_forward != CMD_NEG_FULL) && (cmd_strafe != CMD_NEG_FULL) &&
                  (cmd_rotate != CMD_NEG_FULL))
    else $error("command outside full scale");

  // the straight rule leaves no rotate command
  a_drift_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && drift_clamped) |-> (cmd_rotate == '0))
    else $error("rotate nonzero with drift clamp");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_ready) |=> cmd_valid && $stable(cmd_forward) &&
      $stable(cmd_strafe) && $stable(cmd_rotate) && $stable(drift_clamped))
    else $error("stalled result changed");

endmodule

bind joystick_axis_shaper jas_checker u_jas_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_forward   (cmd.cmd_forward),
  .cmd_strafe    (cmd.cmd_strafe),
  .cmd_rotate    (cmd.cmd_rotate),
  .drift_clamped (cmd.drift_clamped)
);

`default_nettype wire
